FILE: rtl/poi_pkg.sv
// Shared types, constants and lookup functions of the planar odometry integrator.
// Used by poi_ctrl, poi_datapath and planar_odometry_integrator; depends on nothing.
package poi_pkg;

	localparam int CORDIC_STEPS_DEF   = 16;
	localparam int POSITION_WIDTH_DEF = 48;

	localparam int VEL_W   = 16;
	localparam int DT_W    = 20;
	localparam int GAIN_W  = 16;
	localparam int HEAD_W  = 32;
	localparam int OUTP_W  = 48;
	localparam int IDX_W   = 8;
	localparam int CNT_W   = 5;
	localparam int IN_W    = 72;
	localparam int OUT_W   = 128;

	// CORDIC word width and the multiplier operand width.
	localparam int CW      = 34;
	localparam int PROD_W  = 2 * CW;

	localparam logic [CW-1:0] CORDIC_GAIN = 34'd652032874;
	localparam logic [CW-1:0] TURN_K      = 34'd2935890503;

	localparam logic [IDX_W-1:0] REG_LINEAR_GAIN  = 8'd0;
	localparam logic [IDX_W-1:0] REG_ANGULAR_GAIN = 8'd1;
	localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd256;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_MUL,
		ST_UPDATE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_VX,
		OP_VY,
		OP_OM,
		OP_VXC,
		OP_P,
		OP_VYS,
		OP_VXS,
		OP_PHK,
		OP_VYC,
		OP_PLK,
		OP_RHX,
		OP_RLX,
		OP_RHY,
		OP_RLY
	} op_t;

	// Last step of the multiply sequence; it issues nothing and only retires the final product.
	localparam logic [CNT_W-1:0] MUL_LAST = 5'd14;

	typedef struct packed {
		logic             load;
		logic             cordic_step;
		logic [CNT_W-1:0] iter;
		op_t              op;
		logic             update;
	} cmd_t;

	// Products are registered, then retired; a dependent operation issues after the retire.
	function automatic op_t op_at(input logic [CNT_W-1:0] step);
		op_t op;
		unique case (step)
			5'd0:    op = OP_VX;
			5'd1:    op = OP_VY;
			5'd2:    op = OP_OM;
			5'd3:    op = OP_VXC;
			5'd4:    op = OP_P;
			5'd5:    op = OP_VYS;
			5'd6:    op = OP_VXS;
			5'd7:    op = OP_PHK;
			5'd8:    op = OP_VYC;
			5'd9:    op = OP_PLK;
			5'd10:   op = OP_RHX;
			5'd11:   op = OP_RLX;
			5'd12:   op = OP_RHY;
			5'd13:   op = OP_RLY;
			default: op = OP_NONE;
		endcase
		return op;
	endfunction

	// Arctangent of 2^-i as a binary angle, 2^32 per turn.
	function automatic logic [HEAD_W-1:0] atan_at(input logic [CNT_W-1:0] i);
		logic [HEAD_W-1:0] a;
		case (i)
			5'd0:    a = 32'd536870912;
			5'd1:    a = 32'd316933406;
			5'd2:    a = 32'd167458907;
			5'd3:    a = 32'd85004756;
			5'd4:    a = 32'd42667331;
			5'd5:    a = 32'd21354465;
			5'd6:    a = 32'd10679838;
			5'd7:    a = 32'd5340245;
			5'd8:    a = 32'd2670163;
			5'd9:    a = 32'd1335087;
			5'd10:   a = 32'd667544;
			5'd11:   a = 32'd333772;
			5'd12:   a = 32'd166886;
			5'd13:   a = 32'd83443;
			5'd14:   a = 32'd41722;
			5'd15:   a = 32'd20861;
			5'd16:   a = 32'd10430;
			5'd17:   a = 32'd5215;
			5'd18:   a = 32'd2608;
			5'd19:   a = 32'd1304;
			5'd20:   a = 32'd652;
			5'd21:   a = 32'd326;
			5'd22:   a = 32'd163;
			5'd23:   a = 32'd81;
			5'd24:   a = 32'd41;
			5'd25:   a = 32'd20;
			5'd26:   a = 32'd10;
			5'd27:   a = 32'd5;
			5'd28:   a = 32'd3;
			5'd29:   a = 32'd1;
			default: a = 32'd0;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/poi_ctrl.sv
// Sequencer of the odometry integrator: input and output handshakes, CORDIC
// iterations and the multiply schedule. Depends on poi_pkg.
module poi_ctrl #(
	parameter int CORDIC_STEPS = poi_pkg::CORDIC_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output poi_pkg::cmd_t cmd
);

	localparam logic [poi_pkg::CNT_W-1:0] ITER_LAST = poi_pkg::CNT_W'(CORDIC_STEPS - 1);

	poi_pkg::state_t state_q, state_d;
	logic [poi_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;
	logic out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			poi_pkg::ST_IDLE: begin
				cnt_d = '0;
				if (in_valid) state_d = poi_pkg::ST_CORDIC;
			end
			poi_pkg::ST_CORDIC: begin
				if (cnt_q == ITER_LAST) begin
					cnt_d   = '0;
					state_d = poi_pkg::ST_MUL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			poi_pkg::ST_MUL: begin
				if (cnt_q == poi_pkg::MUL_LAST) begin
					cnt_d   = '0;
					state_d = poi_pkg::ST_UPDATE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			poi_pkg::ST_UPDATE: begin
				if (out_free) state_d = poi_pkg::ST_IDLE;
			end
			default: state_d = poi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready        = 1'b0;
		cmd.load        = 1'b0;
		cmd.cordic_step = 1'b0;
		cmd.iter        = cnt_q;
		cmd.op          = poi_pkg::OP_NONE;
		cmd.update      = 1'b0;
		unique case (state_q)
			poi_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			poi_pkg::ST_CORDIC: cmd.cordic_step = 1'b1;
			poi_pkg::ST_MUL:    cmd.op = poi_pkg::op_at(cnt_q);
			poi_pkg::ST_UPDATE: cmd.update = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= poi_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.update) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/poi_datapath.sv
// Datapath of the odometry integrator: gain registers, CORDIC, one shared
// signed multiplier with its accumulators, and the pose registers. Depends on poi_pkg.
module poi_datapath #(
	parameter int POSITION_WIDTH = poi_pkg::POSITION_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  poi_pkg::cmd_t               cmd,
	input  logic [poi_pkg::IN_W-1:0]    in_data,
	input  logic                        cfg_we,
	input  logic [poi_pkg::IDX_W-1:0]   cfg_index,
	input  logic [poi_pkg::GAIN_W-1:0]  cfg_data,
	output logic [poi_pkg::OUTP_W-1:0]  x_position,
	output logic [poi_pkg::OUTP_W-1:0]  y_position,
	output logic [poi_pkg::HEAD_W-1:0]  heading_angle
);

	localparam int CW = poi_pkg::CW;
	localparam int PW = POSITION_WIDTH;
	localparam int SW = 66;
	localparam logic signed [SW-1:0] POS_HI = {{(SW-PW+1){1'b0}}, {(PW-1){1'b1}}};
	localparam logic signed [SW-1:0] POS_LO = {{(SW-PW+1){1'b1}}, {(PW-1){1'b0}}};

	logic [poi_pkg::GAIN_W-1:0] lin_gain_q, ang_gain_q;
	logic signed [poi_pkg::VEL_W-1:0] fwd_q, lat_q, turn_q;
	logic [poi_pkg::DT_W-1:0] dt_q;
	logic signed [PW-1:0] pose_x_q, pose_y_q;
	logic [poi_pkg::HEAD_W-1:0] pose_h_q;

	logic signed [CW-1:0] cx_q, cy_q, cz_q;
	logic flip_q;
	logic signed [CW-1:0] cos_v, sin_v;

	logic signed [CW-1:0] vx_q, vy_q, om_q;
	logic signed [54:0] p_q;
	logic signed [63:0] accx_q, accy_q, dx_q, dy_q;
	logic [63:0] macc_q;
	logic signed [poi_pkg::PROD_W-1:0] prod_q;
	poi_pkg::op_t wb_op_q;

	logic signed [CW-1:0] opa, opb;
	logic [54:0] mag;
	logic signed [poi_pkg::HEAD_W-1:0] h_s;
	logic signed [CW-1:0] h_ext, z_init;
	logic flip_init;
	logic signed [CW-1:0] xs, ys, atan_v;
	logic signed [63:0] prod64;
	logic signed [63:0] dxr, dyr;
	logic signed [SW-1:0] sumx, sumy;
	logic [63:0] hsum;
	logic [poi_pkg::HEAD_W-1:0] m_turn;
	logic signed [63:0] px64, py64;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_gain_q <= poi_pkg::GAIN_RESET;
			ang_gain_q <= poi_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			if (cfg_index == poi_pkg::REG_LINEAR_GAIN) lin_gain_q <= cfg_data;
			else if (cfg_index == poi_pkg::REG_ANGULAR_GAIN) ang_gain_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fwd_q  <= in_data[15:0];
			lat_q  <= in_data[31:16];
			turn_q <= in_data[47:32];
			dt_q   <= in_data[67:48];
		end
	end

	// Fold the heading into [-quarter, +quarter] turn; when folded, the CORDIC cosine and sine are negated afterwards.
	always_comb begin
		h_s   = pose_h_q;
		h_ext = CW'(h_s);
		if (h_ext > 34'sh40000000) begin
			z_init    = h_ext - 34'sh80000000;
			flip_init = 1'b1;
		end else if (h_ext < -34'sh40000000) begin
			z_init    = h_ext + 34'sh80000000;
			flip_init = 1'b1;
		end else begin
			z_init    = h_ext;
			flip_init = 1'b0;
		end
	end

	assign xs     = cx_q >>> cmd.iter;
	assign ys     = cy_q >>> cmd.iter;
	assign atan_v = CW'(poi_pkg::atan_at(cmd.iter));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q   <= poi_pkg::CORDIC_GAIN;
			cy_q   <= '0;
			cz_q   <= z_init;
			flip_q <= flip_init;
		end else if (cmd.cordic_step) begin
			if (!cz_q[CW-1]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - atan_v;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + atan_v;
			end
		end
	end

	assign cos_v = flip_q ? -cx_q : cx_q;
	assign sin_v = flip_q ? -cy_q : cy_q;

	assign mag = p_q[54] ? 55'(-p_q) : p_q;

	// Operand selection for the shared multiplier.
	always_comb begin
		opa = '0;
		opb = '0;
		case (cmd.op)
			poi_pkg::OP_VX:  begin opa = CW'(fwd_q);  opb = CW'(lin_gain_q); end
			poi_pkg::OP_VY:  begin opa = CW'(lat_q);  opb = CW'(lin_gain_q); end
			poi_pkg::OP_OM:  begin opa = CW'(turn_q); opb = CW'(ang_gain_q); end
			poi_pkg::OP_VXC: begin opa = vx_q; opb = cos_v; end
			poi_pkg::OP_P:   begin opa = om_q; opb = CW'(dt_q); end
			poi_pkg::OP_VYS: begin opa = vy_q; opb = sin_v; end
			poi_pkg::OP_VXS: begin opa = vx_q; opb = sin_v; end
			poi_pkg::OP_PHK: begin opa = CW'(mag[54:26]); opb = poi_pkg::TURN_K; end
			poi_pkg::OP_VYC: begin opa = vy_q; opb = cos_v; end
			poi_pkg::OP_PLK: begin opa = CW'(mag[25:0]); opb = poi_pkg::TURN_K; end
			poi_pkg::OP_RHX: begin opa = CW'(signed'(accx_q[63:42])); opb = CW'(dt_q); end
			poi_pkg::OP_RLX: begin opa = CW'(accx_q[41:22]); opb = CW'(dt_q); end
			poi_pkg::OP_RHY: begin opa = CW'(signed'(accy_q[63:42])); opb = CW'(dt_q); end
			poi_pkg::OP_RLY: begin opa = CW'(accy_q[41:22]); opb = CW'(dt_q); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wb_op_q <= poi_pkg::OP_NONE;
		else wb_op_q <= cmd.op;
	end

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
	end

	assign prod64 = prod_q[63:0];

	// Retire the product of the previous cycle into its destination.
	always_ff @(posedge clk) begin
		case (wb_op_q)
			poi_pkg::OP_VX:  vx_q <= prod_q[CW-1:0];
			poi_pkg::OP_VY:  vy_q <= prod_q[CW-1:0];
			poi_pkg::OP_OM:  om_q <= prod_q[CW-1:0];
			poi_pkg::OP_P:   p_q <= prod_q[54:0];
			poi_pkg::OP_VXC: accx_q <= prod64;
			poi_pkg::OP_VYS: accx_q <= accx_q - prod64;
			poi_pkg::OP_VXS: accy_q <= prod64;
			poi_pkg::OP_VYC: accy_q <= accy_q + prod64;
			poi_pkg::OP_PHK: macc_q <= prod64;
			poi_pkg::OP_PLK: macc_q <= macc_q + (prod64 >> 26);
			poi_pkg::OP_RHX: dx_q <= {prod_q[43:0], 20'd0};
			poi_pkg::OP_RLX: dx_q <= dx_q + prod64;
			poi_pkg::OP_RHY: dy_q <= {prod_q[43:0], 20'd0};
			poi_pkg::OP_RLY: dy_q <= dy_q + prod64;
			default: ;
		endcase
	end

	assign dxr  = (dx_q + 64'sd32768) >>> 16;
	assign dyr  = (dy_q + 64'sd32768) >>> 16;
	assign sumx = SW'(pose_x_q) + SW'(dxr);
	assign sumy = SW'(pose_y_q) + SW'(dyr);
	assign hsum = macc_q + 64'd8192;
	assign m_turn = hsum[45:14];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_h_q <= '0;
		end else if (cmd.update) begin
			if (sumx > POS_HI) pose_x_q <= POS_HI[PW-1:0];
			else if (sumx < POS_LO) pose_x_q <= POS_LO[PW-1:0];
			else pose_x_q <= sumx[PW-1:0];
			if (sumy > POS_HI) pose_y_q <= POS_HI[PW-1:0];
			else if (sumy < POS_LO) pose_y_q <= POS_LO[PW-1:0];
			else pose_y_q <= sumy[PW-1:0];
			pose_h_q <= p_q[54] ? pose_h_q - m_turn : pose_h_q + m_turn;
		end
	end

	assign px64 = 64'(pose_x_q);
	assign py64 = 64'(pose_y_q);
	assign x_position    = px64[poi_pkg::OUTP_W-1:0];
	assign y_position    = py64[poi_pkg::OUTP_W-1:0];
	assign heading_angle = pose_h_q;

endmodule

FILE: rtl/planar_odometry_integrator.sv
// Planar dead-reckoning odometry integrator, top level.
// Each item passes the CORDIC iterations, then fourteen operations on the single shared
// multiplier, then the pose update, which waits until the output is free; no new item is
// taken before that update.
// Reset (arst_n low): pose is zero, both gains are 1.0, no result pending.
// Depends on poi_pkg, poi_ctrl and poi_datapath.
module planar_odometry_integrator #(
	parameter int CORDIC_STEPS   = poi_pkg::CORDIC_STEPS_DEF,
	parameter int POSITION_WIDTH = poi_pkg::POSITION_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// forward_velocity[15:0], lateral_velocity[31:16], turn_rate[47:32],
	// elapsed_time[67:48], zero pad[71:68]
	input  logic [poi_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// x_position[47:0], y_position[95:48], heading_angle[127:96]
	output logic [poi_pkg::OUT_W-1:0]   m_tdata,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [poi_pkg::IDX_W-1:0]   cfg_index,
	input  logic [poi_pkg::GAIN_W-1:0]  cfg_data
);

	poi_pkg::cmd_t cmd;
	logic [poi_pkg::OUTP_W-1:0] x_position, y_position;
	logic [poi_pkg::HEAD_W-1:0] heading_angle;

	assign cfg_ready = 1'b1;

	poi_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	poi_datapath #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_data       (s_tdata),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.x_position    (x_position),
		.y_position    (y_position),
		.heading_angle (heading_angle)
	);

	assign m_tdata = {heading_angle, y_position, x_position};

	// Once an item is taken, no further item is taken until its result is produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in flight");

	// A new result only comes out of the update step, never out of idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result raised without a completed update");

endmodule
